FILE: design/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types and constants for the disparity-to-point reprojection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

  localparam int CFG_W = 27;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_STRIDE    = 3'd0,
    REG_FOCAL_X   = 3'd1,
    REG_FOCAL_Y   = 3'd2,
    REG_CENTER_X  = 3'd3,
    REG_CENTER_Y  = 3'd4,
    REG_BASELINE  = 3'd5,
    REG_MAX_DEPTH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] disparity;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pix_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [26:0]        point_z;
    logic [23:0]        packed_color;
  } point_t;

endpackage

`default_nettype wire

FILE: design/dpr_div.sv
// ----------------------------------------------------------------------------
// dpr_div
// Pipelined restoring divider: one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_div #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               out_vld,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem,
  output logic [SW-1:0]      side_out
);

  logic          vld [NW];
  logic [NW-1:0] acc [NW];
  logic [DW-1:0] rm  [NW];
  logic [DW-1:0] dn  [NW];
  logic [SW-1:0] sd  [NW];

  for (genvar gi = 0; gi < NW; gi++) begin : g_stage
    logic          p_vld;
    logic [NW-1:0] p_acc;
    logic [DW-1:0] p_rm;
    logic [DW-1:0] p_dn;
    logic [SW-1:0] p_sd;
    logic [DW:0]   shf;
    logic          ge;

    if (gi == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_acc = num;
      assign p_rm  = '0;
      assign p_dn  = den;
      assign p_sd  = side;
    end else begin : g_next
      assign p_vld = vld[gi-1];
      assign p_acc = acc[gi-1];
      assign p_rm  = rm[gi-1];
      assign p_dn  = dn[gi-1];
      assign p_sd  = sd[gi-1];
    end

    // Bring down the next numerator bit; the numerator shifts out at the top
    // while quotient bits shift in at the bottom of the same register.
    assign shf = {p_rm, p_acc[NW-1]};
    assign ge  = (shf >= {1'b0, p_dn});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi] <= 1'b0;
      end else if (en) begin
        vld[gi] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[gi] <= {p_acc[NW-2:0], ge};
        rm[gi]  <= ge ? DW'(shf - {1'b0, p_dn}) : shf[DW-1:0];
        dn[gi]  <= p_dn;
        sd[gi]  <= p_sd;
      end
    end
  end

  assign out_vld  = vld[NW-1];
  assign quo      = acc[NW-1];
  assign rem      = rm[NW-1];
  assign side_out = sd[NW-1];

endmodule

`default_nettype wire

FILE: design/dpr_skid.sv
// ----------------------------------------------------------------------------
// dpr_skid
// Output register with a skid stage; stalls the pipeline only when full.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_skid import dpr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   tail_vld,
  input  wire point_t tail,
  output logic        advance,
  output logic        point_valid,
  input  wire logic   point_ready,
  output point_t      point
);

  logic   skid_vld;
  point_t skid;
  logic   take;

  assign advance = !skid_vld;
  assign take    = advance && tail_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      skid_vld    <= 1'b0;
    end else if (point_ready || !point_valid) begin
      if (skid_vld) begin
        point_valid <= 1'b1;
        skid_vld    <= 1'b0;
      end else begin
        point_valid <= take;
      end
    end else if (take) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (point_ready || !point_valid) begin
      point <= skid_vld ? skid : tail;
    end else if (take) begin
      skid <= tail;
    end
  end

endmodule

`default_nettype wire

FILE: design/disparity_to_point_reprojection_unit.sv
// Pipeline: 101 register stages from an input transfer to point_valid (input register,
// 12-stage stride divider, product stage, 41-stage depth divider, two arithmetic
// stages, 43-stage X/Y dividers, output register). The divider stage counts set that total.
// Throughput: one pixel per cycle while the skid stage is empty; dropped pixels
// produce no transfer. Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_unit
// Converts a disparity pixel into a colored 3D point in micrometres.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection_unit import dpr_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pix_valid,
  output logic                  pix_ready,
  input  wire pix_t             pix,
  output logic                  point_valid,
  input  wire logic             point_ready,
  output point_t                point,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0] wr_data
);

  typedef struct packed {
    logic  keep;
    pix_t  pix;
  } z_side_t;

  typedef struct packed {
    logic        keep;
    logic        neg;
    logic        zero;
    logic [26:0] z;
    logic [23:0] color;
  } x_side_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } y_side_t;

  // Configuration registers.
  logic [4:0]  stride;
  logic [19:0] focal_x;
  logic [19:0] focal_y;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [19:0] baseline;
  logic [26:0] max_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride    <= 5'd2;
      focal_x   <= '0;
      focal_y   <= '0;
      center_x  <= '0;
      center_y  <= '0;
      baseline  <= 20'd60000;
      max_depth <= 27'd10000000;
    end else if (wr_en) begin
      case (wr_index)
        REG_STRIDE:    stride    <= wr_data[4:0];
        REG_FOCAL_X:   focal_x   <= wr_data[19:0];
        REG_FOCAL_Y:   focal_y   <= wr_data[19:0];
        REG_CENTER_X:  center_x  <= wr_data[15:0];
        REG_CENTER_Y:  center_y  <= wr_data[15:0];
        REG_BASELINE:  baseline  <= wr_data[19:0];
        REG_MAX_DEPTH: max_depth <= wr_data[26:0];
        default: ;
      endcase
    end
  end

  logic advance;
  assign pix_ready = advance;

  // Input register.
  logic s0_vld;
  pix_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (advance) begin
      s0_vld <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0 <= pix;
    end
  end

  // Stride check: column and row remainders.
  logic [4:0] stride_div;
  logic       frame;
  logic       a_vld, b_vld, a_frame;
  logic [4:0] col_rem, row_rem;
  pix_t       a_pix;

  // A stride of zero behaves as a stride of one.
  assign stride_div = (stride == 5'd0) ? 5'd1 : stride;
  assign frame = ({5'b0, s0.column} < 17'(MAX_WIDTH)) &&
                 ({5'b0, s0.row} < 17'(MAX_HEIGHT));

  dpr_div #(.NW(12), .DW(5), .SW($bits(pix_t))) u_col_div (
    .clk(clk), .rst(rst), .en(advance), .in_vld(s0_vld),
    .num(s0.column), .den(stride_div), .side(s0),
    .out_vld(a_vld), .quo(), .rem(col_rem), .side_out(a_pix)
  );

  dpr_div #(.NW(12), .DW(5), .SW(1)) u_row_div (
    .clk(clk), .rst(rst), .en(advance), .in_vld(s0_vld),
    .num(s0.row), .den(stride_div), .side(frame),
    .out_vld(b_vld), .quo(), .rem(row_rem), .side_out(a_frame)
  );

  // Stage 1: focal times baseline, doubled for the Q16.4 / Q11.5 ratio.
  logic        t1_vld;
  logic [40:0] t1_prod;
  z_side_t     t1_side;
  logic [39:0] fxb;
  logic        keep1;

  assign fxb   = 40'(focal_x) * 40'(baseline);
  assign keep1 = a_frame && (col_rem == 5'd0) && (row_rem == 5'd0) &&
                 !a_pix.disparity[15] && (a_pix.disparity != 16'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
    end else if (advance) begin
      t1_vld <= a_vld && b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1_prod      <= {fxb, 1'b0};
      t1_side.keep <= keep1;
      t1_side.pix  <= a_pix;
    end
  end

  // Depth division.
  logic        z_vld;
  logic [40:0] zq;
  z_side_t     zs;

  dpr_div #(.NW(41), .DW(15), .SW($bits(z_side_t))) u_z_div (
    .clk(clk), .rst(rst), .en(advance), .in_vld(t1_vld),
    .num(t1_prod), .den(t1_side.pix.disparity[14:0]), .side(t1_side),
    .out_vld(z_vld), .quo(zq), .rem(), .side_out(zs)
  );

  // Stage 2: depth range check and signed offsets from the principal point.
  logic        keep2;
  logic [16:0] diff_x, diff_y, neg_x, neg_y;
  logic        t2_vld, t2_keep, t2_sx, t2_sy;
  logic [15:0] t2_mx, t2_my;
  logic [26:0] t2_z;
  logic [23:0] t2_color;

  assign keep2  = zs.keep && (zq != 41'd0) && (zq <= {14'b0, max_depth});
  assign diff_x = {1'b0, zs.pix.column, 4'b0} - {1'b0, center_x};
  assign diff_y = {1'b0, zs.pix.row, 4'b0} - {1'b0, center_y};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_vld <= 1'b0;
    end else if (advance) begin
      t2_vld <= z_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t2_keep  <= keep2;
      t2_z     <= zq[26:0];
      t2_sx    <= diff_x[16];
      t2_sy    <= diff_y[16];
      t2_mx    <= diff_x[16] ? neg_x[15:0] : diff_x[15:0];
      t2_my    <= diff_y[16] ? neg_y[15:0] : diff_y[15:0];
      t2_color <= {zs.pix.red, zs.pix.green, zs.pix.blue};
    end
  end

  // Stage 3: offset magnitude times depth.
  logic        t3_vld;
  logic [42:0] t3_px, t3_py;
  x_side_t     t3_xs;
  y_side_t     t3_ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_vld <= 1'b0;
    end else if (advance) begin
      t3_vld <= t2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t3_px       <= 43'(t2_mx) * 43'(t2_z);
      t3_py       <= 43'(t2_my) * 43'(t2_z);
      t3_xs.keep  <= t2_keep;
      t3_xs.neg   <= t2_sx;
      t3_xs.zero  <= (t2_mx == 16'd0);
      t3_xs.z     <= t2_z;
      t3_xs.color <= t2_color;
      t3_ys.neg   <= t2_sy;
      t3_ys.zero  <= (t2_my == 16'd0);
    end
  end

  // Lateral and vertical divisions run side by side.
  logic        x_vld, y_vld;
  logic [42:0] xq, yq;
  x_side_t     xs;
  y_side_t     ys;

  dpr_div #(.NW(43), .DW(20), .SW($bits(x_side_t))) u_x_div (
    .clk(clk), .rst(rst), .en(advance), .in_vld(t3_vld),
    .num(t3_px), .den(focal_x), .side(t3_xs),
    .out_vld(x_vld), .quo(xq), .rem(), .side_out(xs)
  );

  dpr_div #(.NW(43), .DW(20), .SW($bits(y_side_t))) u_y_div (
    .clk(clk), .rst(rst), .en(advance), .in_vld(t3_vld),
    .num(t3_py), .den(focal_y), .side(t3_ys),
    .out_vld(y_vld), .quo(yq), .rem(), .side_out(ys)
  );

  // Applies the sign and saturates to 32 bits. A zero numerator gives zero
  // even when the focal length is zero.
  function automatic logic [31:0] sat_div(input logic neg, input logic zero,
                                          input logic [42:0] q);
    logic [31:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (q[42:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = ((q[42:32] != '0) || (q[31] && (q[30:0] != '0))) ?
          32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  point_t tail;
  logic   tail_vld;

  assign tail_vld          = x_vld && y_vld && xs.keep;
  assign tail.point_x      = sat_div(xs.neg, xs.zero, xq);
  assign tail.point_y      = sat_div(ys.neg, ys.zero, yq);
  assign tail.point_z      = xs.z;
  assign tail.packed_color = xs.color;

  dpr_skid u_skid (
    .clk(clk), .rst(rst), .tail_vld(tail_vld), .tail(tail),
    .advance(advance), .point_valid(point_valid),
    .point_ready(point_ready), .point(point)
  );

endmodule

`default_nettype wire
